### design/skna_pkg.sv
// ----------------------------------------------------------------------------
// skna_pkg
// Shared types and constants for the nerve-activity envelope chain: the
// controller states, the command and status groups, the filter coefficients
// and the divider geometry.
// ----------------------------------------------------------------------------
package skna_pkg;

    localparam int CFG_IW = 3;
    localparam int CFG_DW = 32;

    localparam logic [CFG_IW-1:0] CFG_BASE_LEN  = 3'd0;
    localparam logic [CFG_IW-1:0] CFG_SHORT_LEN = 3'd1;
    localparam logic [CFG_IW-1:0] CFG_LONG_LEN  = 3'd2;
    localparam logic [CFG_IW-1:0] CFG_DECIM     = 3'd3;
    localparam logic [CFG_IW-1:0] CFG_GAIN      = 3'd4;

    localparam logic [12:0] BASE_LEN_RST  = 13'd4000;
    localparam logic [9:0]  SHORT_LEN_RST = 10'd400;
    localparam logic [16:0] LONG_LEN_RST  = 17'd40000;
    localparam logic [6:0]  DECIM_RST     = 7'd40;
    localparam logic [31:0] GAIN_RST      = 32'd26433806;
    localparam logic [6:0]  DECIM_MAX     = 7'd64;

    localparam int FILTER_TAPS = 11;
    localparam int TIW         = 4;

    localparam logic signed [32:0] DEN_Q [0:FILTER_TAPS-1] = '{
        33'sd268435456, -33'sd831077514, 33'sd1710097440, -33'sd2393007846,
        33'sd2666130503, -33'sd2281296092, 33'sd1591443350, -33'sd848273194,
        33'sd358218660, -33'sd100739129, 33'sd19412125
    };
    localparam logic signed [24:0] NUM_Q [0:FILTER_TAPS-1] = '{
        25'sd880258, 25'sd0, -25'sd4401290, 25'sd0, 25'sd8802580, 25'sd0,
        -25'sd8802580, 25'sd0, 25'sd4401290, 25'sd0, -25'sd880258
    };

    localparam logic signed [63:0] Y_LIM    = 64'sd536870912;
    localparam logic signed [63:0] S_LIM    = 64'sd2305843009213693952;
    localparam logic signed [63:0] RND_HALF = 64'sd134217728;
    localparam int COEF_FRAC = 28;
    localparam int NUM_SHIFT = 12;

    localparam int DIV_W    = 64;
    localparam int DIV_STEP = 4;
    localparam int DIV_CYC  = DIV_W / DIV_STEP;
    localparam int DIV_CW   = $clog2(DIV_CYC);

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_BASE,
        ST_BDIV,
        ST_BWAIT,
        ST_YMUL,
        ST_YFIN,
        ST_TMUL,
        ST_TACC,
        ST_MMUL,
        ST_MFIN,
        ST_PUSH,
        ST_SDIV,
        ST_SWAIT,
        ST_LDIV,
        ST_LWAIT,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic load;
        logic base_upd;
        logic bdiv_start;
        logic base_take;
        logic ymul;
        logic yfin;
        logic tmul;
        logic tacc;
        logic mmul;
        logic mfin;
        logic push;
        logic sdiv_start;
        logic short_take;
        logic ldiv_start;
        logic long_take;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic div_done;
        logic tap_last;
        logic out_full;
    } sts_t;

endpackage

### design/skna_ram.sv
// ----------------------------------------------------------------------------
// skna_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module skna_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                                       clk,
    input  logic                                       we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                           wdata,
    input  logic                                       re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                           rdata
);

    logic [WIDTH-1:0] mem [0:DEPTH-1];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### design/skna_div.sv
// ----------------------------------------------------------------------------
// skna_div
// Unsigned restoring divider, four quotient bits per cycle, shared by the
// baseline mean and both envelope means.
// ----------------------------------------------------------------------------
module skna_div #(
    parameter int VW = 17
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [skna_pkg::DIV_W-1:0]    dividend,
    input  logic [VW-1:0]                 divisor,
    output logic                          done,
    output logic [skna_pkg::DIV_W-1:0]    quotient
);

    import skna_pkg::*;

    logic              busy_reg;
    logic              done_reg;
    logic [DIV_CW-1:0] cnt_reg;
    logic [VW:0]       rem_reg;
    logic [DIV_W-1:0]  q_reg;
    logic [VW-1:0]     dsr_reg;
    logic [VW:0]       rem_next;
    logic [DIV_W-1:0]  q_next;

    always_comb
    begin
        rem_next = rem_reg;
        q_next   = q_reg;
        for (int i = 0; i < DIV_STEP; i++)
        begin
            rem_next = {rem_next[VW-1:0], q_next[DIV_W-1]};
            q_next   = {q_next[DIV_W-2:0], 1'b0};
            if (rem_next >= {1'b0, dsr_reg})
            begin
                rem_next  = rem_next - {1'b0, dsr_reg};
                q_next[0] = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == DIV_CW'(DIV_CYC - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            q_reg   <= dividend;
            dsr_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            q_reg   <= q_next;
        end
    end

    assign done     = done_reg;
    assign quotient = q_reg;

endmodule

### design/skna_ctrl.sv
// ----------------------------------------------------------------------------
// skna_ctrl
// Sequencer for one sample: baseline update and division, the serial tap
// loop, scaling, envelope updates and divisions, then result hand-off.
// ----------------------------------------------------------------------------
module skna_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  skna_pkg::sts_t  sts,
    output skna_pkg::cmd_t  cmd
);

    import skna_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:  if (in_valid) state_next = ST_BASE;
            ST_BASE:  state_next = ST_BDIV;
            ST_BDIV:  state_next = ST_BWAIT;
            ST_BWAIT: if (sts.div_done) state_next = ST_YMUL;
            ST_YMUL:  state_next = ST_YFIN;
            ST_YFIN:  state_next = ST_TMUL;
            ST_TMUL:  state_next = ST_TACC;
            ST_TACC:  state_next = sts.tap_last ? ST_MMUL : ST_TMUL;
            ST_MMUL:  state_next = ST_MFIN;
            ST_MFIN:  state_next = ST_PUSH;
            ST_PUSH:  state_next = ST_SDIV;
            ST_SDIV:  state_next = ST_SWAIT;
            ST_SWAIT: if (sts.div_done) state_next = ST_LDIV;
            ST_LDIV:  state_next = ST_LWAIT;
            ST_LWAIT: if (sts.div_done) state_next = ST_DONE;
            ST_DONE:  if (!sts.out_full) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            ST_BASE:  cmd.base_upd   = 1'b1;
            ST_BDIV:  cmd.bdiv_start = 1'b1;
            ST_BWAIT: cmd.base_take  = sts.div_done;
            ST_YMUL:  cmd.ymul       = 1'b1;
            ST_YFIN:  cmd.yfin       = 1'b1;
            ST_TMUL:  cmd.tmul       = 1'b1;
            ST_TACC:  cmd.tacc       = 1'b1;
            ST_MMUL:  cmd.mmul       = 1'b1;
            ST_MFIN:  cmd.mfin       = 1'b1;
            ST_PUSH:  cmd.push       = 1'b1;
            ST_SDIV:  cmd.sdiv_start = 1'b1;
            ST_SWAIT: cmd.short_take = sts.div_done;
            ST_LDIV:  cmd.ldiv_start = 1'b1;
            ST_LWAIT: cmd.long_take  = sts.div_done;
            ST_DONE:  cmd.out_load   = !sts.out_full;
            default:  cmd = '0;
        endcase
    end

endmodule

### design/skna_dp.sv
// ----------------------------------------------------------------------------
// skna_dp
// Datapath: packet offset, baseline ring and mean, serial transposed-form
// bandpass handled one tap at a time, gain scaling, rectification, short
// and long envelope rings with their means, and the result register.
// ----------------------------------------------------------------------------
module skna_dp #(
    parameter int BASE_DEPTH  = 4096,
    parameter int SHORT_DEPTH = 512,
    parameter int LONG_DEPTH  = 65536
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [skna_pkg::CFG_IW-1:0]   cfg_index,
    input  logic [skna_pkg::CFG_DW-1:0]   cfg_data,
    input  logic signed [15:0]            sample,
    input  logic                          first_of_packet,
    input  logic                          last_of_packet,
    input  skna_pkg::cmd_t                cmd,
    output skna_pkg::sts_t                sts,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic signed [15:0]            corrected_sample,
    output logic signed [31:0]            filtered_mv,
    output logic [31:0]                   short_avg_uv,
    output logic                          short_valid,
    output logic [31:0]                   long_avg_uv,
    output logic                          long_valid
);

    import skna_pkg::*;

    localparam int BAW = (BASE_DEPTH > 1) ? $clog2(BASE_DEPTH) : 1;
    localparam int SAW = (SHORT_DEPTH > 1) ? $clog2(SHORT_DEPTH) : 1;
    localparam int LAW = (LONG_DEPTH > 1) ? $clog2(LONG_DEPTH) : 1;
    localparam int BFW = $clog2(BASE_DEPTH + 1);
    localparam int SFW = $clog2(SHORT_DEPTH + 1);
    localparam int LFW = $clog2(LONG_DEPTH + 1);
    localparam int BTW = 16 + BFW;
    localparam int STW = 32 + SFW;
    localparam int LTW = 32 + LFW;
    localparam int VW1 = (BFW > SFW) ? BFW : SFW;
    localparam int VW  = (VW1 > LFW) ? VW1 : LFW;

    // configuration
    logic [12:0] base_len_reg;
    logic [9:0]  short_len_reg;
    logic [16:0] long_len_reg;
    logic [6:0]  decim_reg;
    logic [31:0] gain_reg;

    // packet state
    logic [15:0] prev_end_reg;
    logic [15:0] offset_reg;
    logic [5:0]  pos_reg;
    logic [15:0] shifted_reg;
    logic        last_reg;
    logic        svalid_reg;

    // running sums
    logic signed [BTW-1:0] base_total_reg;
    logic [BFW-1:0]        base_fill_reg;
    logic [BAW-1:0]        base_ptr_reg;
    logic [STW-1:0]        short_total_reg;
    logic [SFW-1:0]        short_fill_reg;
    logic [SAW-1:0]        short_ptr_reg;
    logic [LTW-1:0]        long_total_reg;
    logic [LFW-1:0]        long_fill_reg;
    logic [LAW-1:0]        long_ptr_reg;

    // filter
    logic signed [63:0] tap_reg [0:FILTER_TAPS-2];
    logic [TIW-1:0]     tap_idx_reg;
    logic signed [15:0] corr_reg;
    logic signed [40:0] pnum_reg;
    logic signed [63:0] pden_reg;
    logic signed [30:0] y_reg;
    logic signed [63:0] pmv_reg;
    logic signed [31:0] mv_reg;
    logic               base_neg_reg;
    logic [31:0]        short_avg_reg;
    logic [31:0]        long_avg_reg;

    // results
    logic               out_valid_reg;
    logic signed [15:0] o_corr_reg;
    logic signed [31:0] o_mv_reg;
    logic [31:0]        o_savg_reg;
    logic               o_sval_reg;
    logic [31:0]        o_lavg_reg;
    logic               o_lval_reg;

    logic [31:0] blen_w, slen_w, llen_w;
    logic [31:0] b_old_w, s_old_w, l_old_w;
    logic [31:0] b_ptr_w, s_ptr_w, l_ptr_w;
    logic [15:0] b_rdata;
    logic [31:0] s_rdata, l_rdata;
    logic [15:0] offset_next, shifted_next;
    logic [6:0]  dstep;
    logic [5:0]  pos_base;
    logic [6:0]  pos_inc;
    logic        b_drop, s_drop, l_drop;
    logic [31:0] rect;
    logic signed [BTW-1:0] base_abs;
    logic        div_start, div_done;
    logic [DIV_W-1:0] div_dividend, div_q;
    logic [VW-1:0]    div_divisor;
    logic [DIV_W-1:0] s_t64, l_t64;
    logic [15:0]      mean16;
    logic             tap_last;
    logic [TIW-1:0]   nxt_idx;
    logic signed [63:0] pnum_ext, y_sum, y_sh, nz, nxt, mv_sum, mv_sh;
    logic signed [40:0] pnum_w;
    logic signed [63:0] pden_w;
    logic signed [63:0] pmv_w;

    always_comb
    begin
        blen_w = (base_len_reg == '0) ? 32'd1 :
                 ((32'(base_len_reg) > 32'(BASE_DEPTH)) ? 32'(BASE_DEPTH) : 32'(base_len_reg));
        slen_w = (short_len_reg == '0) ? 32'd1 :
                 ((32'(short_len_reg) > 32'(SHORT_DEPTH)) ? 32'(SHORT_DEPTH) : 32'(short_len_reg));
        llen_w = (long_len_reg == '0) ? 32'd1 :
                 ((32'(long_len_reg) > 32'(LONG_DEPTH)) ? 32'(LONG_DEPTH) : 32'(long_len_reg));

        b_old_w = (32'(base_ptr_reg) >= 32'(base_fill_reg)) ?
                  32'(base_ptr_reg) - 32'(base_fill_reg) :
                  32'(base_ptr_reg) + 32'(BASE_DEPTH) - 32'(base_fill_reg);
        s_old_w = (32'(short_ptr_reg) >= 32'(short_fill_reg)) ?
                  32'(short_ptr_reg) - 32'(short_fill_reg) :
                  32'(short_ptr_reg) + 32'(SHORT_DEPTH) - 32'(short_fill_reg);
        l_old_w = (32'(long_ptr_reg) >= 32'(long_fill_reg)) ?
                  32'(long_ptr_reg) - 32'(long_fill_reg) :
                  32'(long_ptr_reg) + 32'(LONG_DEPTH) - 32'(long_fill_reg);

        b_ptr_w = (32'(base_ptr_reg) + 32'd1 >= 32'(BASE_DEPTH)) ? 32'd0 :
                  32'(base_ptr_reg) + 32'd1;
        s_ptr_w = (32'(short_ptr_reg) + 32'd1 >= 32'(SHORT_DEPTH)) ? 32'd0 :
                  32'(short_ptr_reg) + 32'd1;
        l_ptr_w = (32'(long_ptr_reg) + 32'd1 >= 32'(LONG_DEPTH)) ? 32'd0 :
                  32'(long_ptr_reg) + 32'd1;

        b_drop = 32'(base_fill_reg) >= blen_w;
        s_drop = 32'(short_fill_reg) >= slen_w;
        l_drop = 32'(long_fill_reg) >= llen_w;

        offset_next  = first_of_packet ? (prev_end_reg - sample) : offset_reg;
        shifted_next = sample + offset_next;

        dstep    = (decim_reg == '0) ? 7'd1 : ((decim_reg > DECIM_MAX) ? DECIM_MAX : decim_reg);
        pos_base = first_of_packet ? 6'd0 : pos_reg;
        pos_inc  = {1'b0, pos_base} + 7'd1;

        rect = mv_reg[31] ? (32'd0 - mv_reg) : mv_reg;

        base_abs = base_total_reg[BTW-1] ? -base_total_reg : base_total_reg;
        s_t64    = DIV_W'(short_total_reg);
        l_t64    = DIV_W'(long_total_reg);
        mean16   = base_neg_reg ? (16'd0 - div_q[15:0]) : div_q[15:0];

        tap_last = (tap_idx_reg == TIW'(FILTER_TAPS - 1));
        nxt_idx  = tap_last ? '0 : tap_idx_reg;
        nxt      = tap_last ? 64'sd0 : tap_reg[nxt_idx];

        pnum_w   = NUM_Q[tap_idx_reg] * corr_reg;
        pden_w   = DEN_Q[tap_idx_reg] * y_reg;
        pnum_ext = {{23{pnum_reg[40]}}, pnum_reg} <<< NUM_SHIFT;
        y_sum    = pnum_ext + tap_reg[0] + RND_HALF;
        y_sh     = y_sum >>> COEF_FRAC;
        nz       = pnum_ext + nxt - pden_reg;
        pmv_w    = y_reg * $signed({1'b0, gain_reg});
        mv_sum   = pmv_reg + RND_HALF;
        mv_sh    = mv_sum >>> COEF_FRAC;
    end

    always_comb
    begin
        div_start   = cmd.bdiv_start | cmd.sdiv_start | cmd.ldiv_start;
        div_dividend = DIV_W'(base_abs);
        div_divisor  = VW'(base_fill_reg);
        if (cmd.sdiv_start)
        begin
            div_dividend = (s_t64 << 10) - (s_t64 << 4) - (s_t64 << 3);
            div_divisor  = VW'(short_fill_reg);
        end
        else if (cmd.ldiv_start)
        begin
            div_dividend = (l_t64 << 10) - (l_t64 << 4) - (l_t64 << 3);
            div_divisor  = VW'(long_fill_reg);
        end
    end

    skna_div #(
        .VW (VW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_q)
    );

    skna_ram #(
        .WIDTH (16),
        .DEPTH (BASE_DEPTH)
    ) u_base_ring (
        .clk   (clk),
        .we    (cmd.base_upd),
        .waddr (base_ptr_reg),
        .wdata (shifted_reg),
        .re    (cmd.load),
        .raddr (b_old_w[BAW-1:0]),
        .rdata (b_rdata)
    );

    skna_ram #(
        .WIDTH (32),
        .DEPTH (SHORT_DEPTH)
    ) u_short_ring (
        .clk   (clk),
        .we    (cmd.push),
        .waddr (short_ptr_reg),
        .wdata (rect),
        .re    (cmd.load),
        .raddr (s_old_w[SAW-1:0]),
        .rdata (s_rdata)
    );

    skna_ram #(
        .WIDTH (32),
        .DEPTH (LONG_DEPTH)
    ) u_long_ring (
        .clk   (clk),
        .we    (cmd.push),
        .waddr (long_ptr_reg),
        .wdata (rect),
        .re    (cmd.load),
        .raddr (l_old_w[LAW-1:0]),
        .rdata (l_rdata)
    );

    // configuration, packet and running-sum state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_len_reg    <= BASE_LEN_RST;
            short_len_reg   <= SHORT_LEN_RST;
            long_len_reg    <= LONG_LEN_RST;
            decim_reg       <= DECIM_RST;
            gain_reg        <= GAIN_RST;
            prev_end_reg    <= '0;
            offset_reg      <= '0;
            pos_reg         <= '0;
            base_total_reg  <= '0;
            base_fill_reg   <= '0;
            base_ptr_reg    <= '0;
            short_total_reg <= '0;
            short_fill_reg  <= '0;
            short_ptr_reg   <= '0;
            long_total_reg  <= '0;
            long_fill_reg   <= '0;
            long_ptr_reg    <= '0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    CFG_BASE_LEN:
                    begin
                        base_len_reg   <= cfg_data[12:0];
                        base_fill_reg  <= '0;
                        base_total_reg <= '0;
                    end
                    CFG_SHORT_LEN:
                    begin
                        short_len_reg   <= cfg_data[9:0];
                        short_fill_reg  <= '0;
                        short_total_reg <= '0;
                    end
                    CFG_LONG_LEN:
                    begin
                        long_len_reg   <= cfg_data[16:0];
                        long_fill_reg  <= '0;
                        long_total_reg <= '0;
                    end
                    CFG_DECIM: decim_reg <= cfg_data[6:0];
                    CFG_GAIN:  gain_reg  <= cfg_data[31:0];
                    default:   ;
                endcase
            end
            if (cmd.load)
            begin
                offset_reg <= offset_next;
                if (last_of_packet)
                begin
                    prev_end_reg <= shifted_next;
                end
                pos_reg <= (pos_inc >= dstep) ? 6'd0 : pos_inc[5:0];
            end
            if (cmd.base_upd)
            begin
                base_total_reg <= base_total_reg
                                  - (b_drop ? {{(BTW-16){b_rdata[15]}}, b_rdata} : '0)
                                  + {{(BTW-16){shifted_reg[15]}}, shifted_reg};
                base_fill_reg  <= b_drop ? base_fill_reg : base_fill_reg + 1'b1;
                base_ptr_reg   <= b_ptr_w[BAW-1:0];
            end
            if (cmd.push)
            begin
                short_total_reg <= short_total_reg - (s_drop ? STW'(s_rdata) : '0)
                                   + STW'(rect);
                short_fill_reg  <= s_drop ? short_fill_reg : short_fill_reg + 1'b1;
                short_ptr_reg   <= s_ptr_w[SAW-1:0];
                long_total_reg  <= long_total_reg - (l_drop ? LTW'(l_rdata) : '0)
                                   + LTW'(rect);
                long_fill_reg   <= l_drop ? long_fill_reg : long_fill_reg + 1'b1;
                long_ptr_reg    <= l_ptr_w[LAW-1:0];
            end
        end
    end

    // filter taps and index
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < FILTER_TAPS - 1; i++)
            begin
                tap_reg[i] <= '0;
            end
            tap_idx_reg <= '0;
        end
        else
        begin
            if (cmd.load)
            begin
                tap_idx_reg <= '0;
            end
            else if (cmd.yfin)
            begin
                tap_idx_reg <= TIW'(1);
            end
            else if (cmd.tacc)
            begin
                tap_reg[TIW'(tap_idx_reg - 1'b1)] <=
                    (nz > S_LIM) ? S_LIM : ((nz < -S_LIM) ? -S_LIM : nz);
                tap_idx_reg <= tap_idx_reg + 1'b1;
            end
        end
    end

    // per-item working registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            shifted_reg <= shifted_next;
            last_reg    <= last_of_packet;
            svalid_reg  <= (pos_base == 6'd0);
        end
        if (cmd.bdiv_start)
        begin
            base_neg_reg <= base_total_reg[BTW-1];
        end
        if (cmd.base_take)
        begin
            corr_reg <= shifted_reg - mean16;
        end
        if (cmd.ymul || cmd.tmul)
        begin
            pnum_reg <= pnum_w;
            pden_reg <= pden_w;
        end
        if (cmd.yfin)
        begin
            y_reg <= (y_sh > Y_LIM) ? Y_LIM[30:0] :
                     ((y_sh < -Y_LIM) ? 31'(-Y_LIM) : y_sh[30:0]);
        end
        if (cmd.mmul)
        begin
            pmv_reg <= pmv_w;
        end
        if (cmd.mfin)
        begin
            mv_reg <= (mv_sh > 64'sd2147483647) ? 32'sh7FFFFFFF :
                      ((mv_sh < -64'sd2147483648) ? 32'sh80000000 : mv_sh[31:0]);
        end
        if (cmd.short_take)
        begin
            short_avg_reg <= (div_q[DIV_W-1:40] != '0) ? 32'hFFFFFFFF : div_q[39:8];
        end
        if (cmd.long_take)
        begin
            long_avg_reg <= (div_q[DIV_W-1:40] != '0) ? 32'hFFFFFFFF : div_q[39:8];
        end
        if (cmd.out_load)
        begin
            o_corr_reg <= corr_reg;
            o_mv_reg   <= mv_reg;
            o_savg_reg <= svalid_reg ? short_avg_reg : 32'd0;
            o_sval_reg <= svalid_reg;
            o_lavg_reg <= last_reg ? long_avg_reg : 32'd0;
            o_lval_reg <= last_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign sts.div_done = div_done;
    assign sts.tap_last = tap_last;
    assign sts.out_full = out_valid_reg & ~out_ready;

    assign out_valid        = out_valid_reg;
    assign corrected_sample = o_corr_reg;
    assign filtered_mv      = o_mv_reg;
    assign short_avg_uv     = o_savg_reg;
    assign short_valid      = o_sval_reg;
    assign long_avg_uv      = o_lavg_reg;
    assign long_valid       = o_lval_reg;

endmodule

### design/skna_envelope_chain_unit.sv
// samples are taken one at a time: in_ready is high only while idle
// pace set by three divisions on the shared divider and the ten-tap loop,
// one tap at a time on one multiplier pair
// the next sample is taken while the previous result waits in the output register
// reset: asynchronous, clears offsets, sums, fills, pointers and filter state;
// rings need no clearing pass since only entries written since the last clear are read
// ----------------------------------------------------------------------------
// skna_envelope_chain_unit
// Top level of the nerve-activity envelope chain: controller and datapath.
// ----------------------------------------------------------------------------
module skna_envelope_chain_unit #(
    parameter int BASE_DEPTH  = 4096,
    parameter int SHORT_DEPTH = 512,
    parameter int LONG_DEPTH  = 65536
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [skna_pkg::CFG_IW-1:0]   cfg_index,
    input  logic [skna_pkg::CFG_DW-1:0]   cfg_data,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic signed [15:0]            sample,
    input  logic                          first_of_packet,
    input  logic                          last_of_packet,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic signed [15:0]            corrected_sample,
    output logic signed [31:0]            filtered_mv,
    output logic [31:0]                   short_avg_uv,
    output logic                          short_valid,
    output logic [31:0]                   long_avg_uv,
    output logic                          long_valid
);

    import skna_pkg::*;

    cmd_t cmd;
    sts_t sts;

    skna_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    skna_dp #(
        .BASE_DEPTH  (BASE_DEPTH),
        .SHORT_DEPTH (SHORT_DEPTH),
        .LONG_DEPTH  (LONG_DEPTH)
    ) u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .sample           (sample),
        .first_of_packet  (first_of_packet),
        .last_of_packet   (last_of_packet),
        .cmd              (cmd),
        .sts              (sts),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .corrected_sample (corrected_sample),
        .filtered_mv      (filtered_mv),
        .short_avg_uv     (short_avg_uv),
        .short_valid      (short_valid),
        .long_avg_uv      (long_avg_uv),
        .long_valid       (long_valid)
    );

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("accepted a beat while busy");

    a_div_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        sts.div_done |=> !sts.div_done)
        else $error("divider done longer than one cycle");

    a_short_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !short_valid |-> short_avg_uv == 32'd0)
        else $error("short mean without short flag");

    a_long_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !long_valid |-> long_avg_uv == 32'd0)
        else $error("long mean without long flag");

endmodule
